// ----- hw/rtl/sorted_priority_queue_defines.svh -----
// Assertion macros for the sorted priority queue checker.
// Depends on nothing; included by the checker file.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package spq_pkg;

  // Fixed field widths of the channels
  localparam int PRIO_W      = 32;
  localparam int ELEM_PORT_W = 32;
  localparam int STATUS_W    = 2;

  // Operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEQ_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ENQ_FULL  = 2'd2;

  // Per-beat command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert the new entry, shift the tail right
    logic rem;  // drop the head, shift everything left
  } spq_ctrl_t;

endpackage

// ----- hw/rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: cell chain, entry count, result buffer.
// Depends on spq_pkg, spq_cell and spq_outbuf.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_ready   | op, elem, priority_req
//   out     | output    | out_valid / out_ready | head_elem, head_priority, count,
//           |           |                      | is_empty, status
//
// One beat per cycle while in_ready is high: every cell compares its slot with
// the new priority and shifts in the same cycle. A result is pushed into a
// two-beat result buffer when its input beat is taken; in_ready drops only
// when that buffer is full.
// Reset (rst, synchronous) empties the queue and the buffer; slot contents
// are left as they are and are never read until written.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int CAPACITY  = 16,
  parameter int ELEM_BITS = 32,
  parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [spq_pkg::ELEM_PORT_W-1:0] elem,
  input  logic [spq_pkg::PRIO_W-1:0]      priority_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spq_pkg::ELEM_PORT_W-1:0] head_elem,
  output logic [spq_pkg::PRIO_W-1:0]      head_priority,
  output logic [CNT_W-1:0]                count,
  output logic                            is_empty,
  output logic [spq_pkg::STATUS_W-1:0]    status
);
  import spq_pkg::*;

  // Stored element width: the element port carries at most ELEM_PORT_W bits
  localparam int SW    = (ELEM_BITS < ELEM_PORT_W) ? ELEM_BITS : ELEM_PORT_W;
  localparam int RES_W = ELEM_PORT_W + PRIO_W + CNT_W + 1 + STATUS_W;

  logic [CNT_W-1:0]    entry_count;
  logic [CNT_W-1:0]    entry_count_next;
  logic                accept;
  logic                full;
  logic                empty;
  logic                buf_full;
  spq_ctrl_t           ctrl;
  logic [STATUS_W-1:0] status_now;
  logic [SW-1:0]       new_elem;
  logic [RES_W-1:0]    res_in;
  logic [RES_W-1:0]    res_out;

  logic [SW-1:0]     cell_elem      [CAPACITY];
  logic [PRIO_W-1:0] cell_prio      [CAPACITY];
  logic [SW-1:0]     cell_elem_next [CAPACITY];
  logic [PRIO_W-1:0] cell_prio_next [CAPACITY];
  logic              cell_after     [CAPACITY];

  assign accept   = in_valid && in_ready;
  assign in_ready = !buf_full;
  assign full     = (entry_count == CNT_W'(CAPACITY));
  assign empty    = (entry_count == '0);
  assign new_elem = elem[SW-1:0];

  // Command for the chain and the status of this beat
  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    status_now = ST_OK;
    if (accept) begin
      if (op == OP_ENQ) begin
        if (full) begin
          status_now = ST_ENQ_FULL;
        end else begin
          ctrl.ins = 1'b1;
        end
      end else begin
        if (empty) begin
          status_now = ST_DEQ_EMPTY;
        end else begin
          ctrl.rem = 1'b1;
        end
      end
    end
  end

  // Entry count
  always_comb begin
    entry_count_next = entry_count;
    if (ctrl.ins) begin
      entry_count_next = entry_count + CNT_W'(1);
    end else if (ctrl.rem) begin
      entry_count_next = entry_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
    end
  end

  // Cell chain; slot 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic              occ;
    logic              left_after;
    logic [SW-1:0]     left_elem;
    logic [PRIO_W-1:0] left_prio;
    logic [SW-1:0]     right_elem;
    logic [PRIO_W-1:0] right_prio;

    assign occ = (CNT_W'(i) < entry_count);

    if (i == 0) begin : g_first
      assign left_after = 1'b1;
      assign left_elem  = new_elem;
      assign left_prio  = priority_req;
    end else begin : g_mid
      assign left_after = cell_after[i-1];
      assign left_elem  = cell_elem[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_elem = cell_elem[i];
      assign right_prio = cell_prio[i];
    end else begin : g_inner
      assign right_elem = cell_elem[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell #(
      .W (SW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ),
      .left_after (left_after),
      .new_elem   (new_elem),
      .new_prio   (priority_req),
      .left_elem  (left_elem),
      .left_prio  (left_prio),
      .right_elem (right_elem),
      .right_prio (right_prio),
      .after      (cell_after[i]),
      .elem       (cell_elem[i]),
      .prio       (cell_prio[i]),
      .elem_next  (cell_elem_next[i]),
      .prio_next  (cell_prio_next[i])
    );
  end

  // Result beat: head after this step, zeros when the queue ends up empty
  always_comb begin
    if (entry_count_next == '0) begin
      res_in = {{ELEM_PORT_W{1'b0}}, {PRIO_W{1'b0}}, entry_count_next, 1'b1, status_now};
    end else begin
      res_in = {ELEM_PORT_W'(cell_elem_next[0]), cell_prio_next[0], entry_count_next,
                1'b0, status_now};
    end
  end

  spq_outbuf #(
    .W (RES_W)
  ) u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res_in),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res_out)
  );

  assign {head_elem, head_priority, count, is_empty, status} = res_out;

endmodule

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and picks its next value
// from the new entry or a neighbor. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell #(
  parameter int W = 32
) (
  input  logic                       clk,
  input  spq_pkg::spq_ctrl_t         ctrl,
  input  logic                       occ,
  input  logic                       left_after,
  input  logic [W-1:0]               new_elem,
  input  logic [spq_pkg::PRIO_W-1:0] new_prio,
  input  logic [W-1:0]               left_elem,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  logic [W-1:0]               right_elem,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio,
  output logic                       after,
  output logic [W-1:0]               elem,
  output logic [spq_pkg::PRIO_W-1:0] prio,
  output logic [W-1:0]               elem_next,
  output logic [spq_pkg::PRIO_W-1:0] prio_next
);
  import spq_pkg::*;

  // New entry belongs behind this slot (ties stay in arrival order)
  assign after = occ && (prio <= new_prio);

  // Next value: keep, take new entry, take left neighbor, or take right
  always_comb begin
    elem_next = elem;
    prio_next = prio;
    if (ctrl.ins && !after) begin
      if (left_after) begin
        elem_next = new_elem;
        prio_next = new_prio;
      end else begin
        elem_next = left_elem;
        prio_next = left_prio;
      end
    end else if (ctrl.rem) begin
      elem_next = right_elem;
      prio_next = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    elem <= elem_next;
    prio <= prio_next;
  end

endmodule

// ----- hw/rtl/spq_outbuf.sv -----
// Two-beat result buffer between the cell chain and the output channel.
// Depends on spq_pkg only by convention; payload is a packed vector.
`timescale 1ns / 1ps

module spq_outbuf #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  import spq_pkg::*;

  logic [W-1:0] d0;
  logic [W-1:0] d1;
  logic [1:0]   fill;
  logic         pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (fill != 2'd0);
  assign full      = (fill == 2'd2);
  assign out_data  = d0;

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (push && !pop) begin
      fill <= fill + 2'd1;
    end else if (pop && !push) begin
      fill <= fill - 2'd1;
    end
  end

  // Data slots: d0 is the beat on the port
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (fill == 2'd2) begin
        d0 <= d1;
        d1 <= push_data;
      end else begin
        d0 <= push_data;
      end
    end else if (pop) begin
      d0 <= d1;
    end else if (push) begin
      if (fill == 2'd0) begin
        d0 <= push_data;
      end else begin
        d1 <= push_data;
      end
    end
  end

endmodule

// ----- hw/rtl/spq_checker.sv -----
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_defines.svh.
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"

module spq_checker #(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [spq_pkg::ELEM_PORT_W-1:0] head_elem,
  input logic [spq_pkg::PRIO_W-1:0]      head_priority,
  input logic [CNT_W-1:0]                count,
  input logic                            is_empty,
  input logic [spq_pkg::STATUS_W-1:0]    status
);
  import spq_pkg::*;

  localparam int BEAT_W = ELEM_PORT_W + PRIO_W + CNT_W + 1 + STATUS_W;

  logic              head_zero;
  logic              at_cap;
  logic              full_drop;
  logic              deq_miss;
  logic              stalled;
  logic [BEAT_W-1:0] out_beat;

  // Terms shared by the checks below
  assign head_zero = (head_elem == '0) && (head_priority == '0);
  assign at_cap    = (count == CNT_W'(CAPACITY));
  assign full_drop = out_valid && (status == ST_ENQ_FULL);
  assign deq_miss  = out_valid && (status == ST_DEQ_EMPTY);
  assign stalled   = out_valid && !out_ready;
  assign out_beat  = {head_elem, head_priority, count, is_empty, status};

  // Empty flag tracks the count
  `SPQ_ASSERT_NOW(a_empty_flag, out_valid, is_empty == (count == '0), "empty flag mismatch")

  // Empty queue reports a zero head
  `SPQ_ASSERT_NOW(a_empty_head, out_valid && is_empty, head_zero, "nonzero head when empty")

  // A dropped enqueue means the queue was full
  `SPQ_ASSERT_NOW(a_full_drop, full_drop, at_cap, "full drop with room left")

  // A rejected dequeue leaves the queue empty
  `SPQ_ASSERT_NOW(a_empty_deq, deq_miss, is_empty, "empty dequeue on nonempty queue")

  // Stalled result holds
  `SPQ_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_beat), "stalled beat changed")

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY (CAPACITY),
  .CNT_W    (CNT_W)
) u_spq_checker (.*);
